// ===== sv/fbla_pkg.sv =====
// types, constants and codes shared by the free block list allocator
`timescale 1ns / 1ps
package fbla_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int UNDO_DEPTH = 32;
    localparam int ADDR_BITS  = 32;
    localparam int LIST_MAX   = 32;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int UIDX_W = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
    localparam int UCNT_W = $clog2(UNDO_DEPTH + 1);
    localparam int LCNT_W = $clog2(LIST_MAX + 1);

    localparam logic [32:0] ADDR_LIMIT = 33'(64'(1) << ADDR_BITS);
    localparam logic [31:0] ADDR_MASK  = 32'((64'(1) << ADDR_BITS) - 64'(1));

    typedef enum logic [3:0] {
        CMD_ADD         = 4'd0,
        CMD_CARVE_IDX   = 4'd1,
        CMD_CARVE_FRONT = 4'd2,
        CMD_CARVE_RANGE = 4'd3,
        CMD_UNDO        = 4'd4,
        CMD_CONTAINS    = 4'd5,
        CMD_FIRST_FIT   = 4'd6,
        CMD_ALL_FITS    = 4'd7,
        CMD_TOTAL       = 4'd8,
        CMD_READ        = 4'd9
    } cmd_e;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_BAD       = 2'd3
    } status_e;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_ADD_FIN,
        S_LIST_PUSH,
        S_LIST_END,
        S_CARVE_RD,
        S_CARVE_LD,
        S_CARVE_CALC,
        S_CARVE_DEC,
        S_UNDO_RD,
        S_UNDO_DEC,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_EMIT
    } state_e;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [4:0]  index;
        logic [31:0] address;
        logic [31:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_index;
        logic [31:0] block_start;
        logic [31:0] block_length;
        logic [37:0] total_free;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } tbl_entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [1:0]       pieces;
        logic [31:0]      start;
        logic [31:0]      length;
    } undo_rec_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        tbl_entry_t       wdata;
        logic [IDX_W-1:0] raddr;
    } tbl_port_t;

    typedef struct packed {
        logic              we;
        logic [UIDX_W-1:0] waddr;
        undo_rec_t         wdata;
        logic [UIDX_W-1:0] raddr;
    } undo_port_t;

endpackage

// ===== sv/fbla_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fbla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fbla_ctrl.sv =====
// command sequencer: table walks, carve, undo, shifting and result register
`timescale 1ns / 1ps
module fbla_ctrl
    import fbla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    output tbl_port_t  tbl_port,
    input  tbl_entry_t tbl_rdata,
    output undo_port_t undo_port,
    input  undo_rec_t  undo_rdata
);

    state_e            state_reg, state_next;
    logic [3:0]        cmd_reg, cmd_next;
    logic [4:0]        idx_reg, idx_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       len_reg, len_next;
    logic [32:0]       cut_reg, cut_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [UCNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    tbl_entry_t        ins_reg, ins_next;
    logic [32:0]       prev_end_reg, prev_end_next;
    logic              has_prev_reg, has_prev_next;
    logic [31:0]       cs_reg, cs_next;
    logic [31:0]       cl_reg, cl_next;
    logic [IDX_W-1:0]  cidx_reg, cidx_next;
    logic [31:0]       ca_reg, ca_next;
    logic [32:0]       e_reg, e_next;
    logic [32:0]       cutc_reg, cutc_next;
    logic [37:0]       sum_reg, sum_next;
    logic [LCNT_W-1:0] found_reg, found_next;
    rsp_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    rsp_t              cand_reg, cand_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            depth_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            depth_reg      <= depth_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        cut_reg      <= cut_next;
        i_reg        <= i_next;
        pos_reg      <= pos_next;
        ins_reg      <= ins_next;
        prev_end_reg <= prev_end_next;
        has_prev_reg <= has_prev_next;
        cs_reg       <= cs_next;
        cl_reg       <= cl_next;
        cidx_reg     <= cidx_next;
        ca_reg       <= ca_next;
        e_reg        <= e_next;
        cutc_reg     <= cutc_next;
        sum_reg      <= sum_next;
        found_reg    <= found_next;
        pend_reg     <= pend_next;
        cand_reg     <= cand_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        logic [31:0]      a;
        logic [CNT_W-1:0] i_inc;
        logic [CNT_W-1:0] i_dec;
        logic [CNT_W-1:0] upos;
        logic             last_i;
        logic             hit;
        logic             out_free;
        logic             nb;
        logic             na;
        rsp_t             blank;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        cut_next        = cut_reg;
        count_next      = count_reg;
        depth_next      = depth_reg;
        i_next          = i_reg;
        pos_next        = pos_reg;
        ins_next        = ins_reg;
        prev_end_next   = prev_end_reg;
        has_prev_next   = has_prev_reg;
        cs_next         = cs_reg;
        cl_next         = cl_reg;
        cidx_next       = cidx_reg;
        ca_next         = ca_reg;
        e_next          = e_reg;
        cutc_next       = cutc_reg;
        sum_next        = sum_reg;
        found_next      = found_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cand_next       = cand_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        tbl_port        = '0;
        undo_port       = '0;

        a        = req.address & ADDR_MASK;
        i_inc    = i_reg + 1'b1;
        i_dec    = i_reg - 1'b1;
        upos     = CNT_W'(undo_rdata.pos);
        last_i   = (i_inc == count_reg);
        hit      = 1'b0;
        out_free = !out_valid_reg || rsp_ready;
        nb       = ca_reg > cs_reg;
        na       = e_reg > cutc_reg;
        blank       = '0;
        blank.last  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req.cmd;
                    idx_next        = req.index;
                    addr_next       = a;
                    len_next        = req.length;
                    cut_next        = {1'b0, a} + {1'b0, req.length};
                    res_next        = blank;
                    i_next          = '0;
                    sum_next        = '0;
                    found_next      = '0;
                    pend_valid_next = 1'b0;
                    has_prev_next   = 1'b0;
                    state_next      = S_SCAN_RD;
                    unique case (req.cmd)
                        CMD_ADD:
                        begin
                            if (req.length == '0 ||
                                ({1'b0, a} + {1'b0, req.length}) > ADDR_LIMIT)
                            begin
                                res_next.status = STS_BAD;
                                state_next      = S_EMIT;
                            end
                            else if (32'(count_reg) >= MAX_BLOCKS)
                            begin
                                res_next.status = STS_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                ins_next   = '{start: a, length: req.length};
                                pos_next   = '0;
                                i_next     = count_reg;
                                state_next = S_SHUP_RD;
                            end
                        end
                        CMD_CARVE_IDX, CMD_CARVE_FRONT:
                        begin
                            res_next.entry_index = req.index;
                            if (32'(req.index) >= 32'(count_reg))
                            begin
                                res_next.status = STS_BAD;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_CARVE_RD;
                            end
                        end
                        CMD_CARVE_RANGE, CMD_CONTAINS, CMD_FIRST_FIT, CMD_ALL_FITS:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STS_NOT_FOUND;
                                state_next      = S_EMIT;
                            end
                        end
                        CMD_UNDO:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_next.status = STS_BAD;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_UNDO_RD;
                            end
                        end
                        CMD_TOTAL:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        CMD_READ:
                        begin
                            res_next.entry_index = req.index;
                            if (32'(req.index) >= 32'(count_reg))
                            begin
                                res_next.status = STS_BAD;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                i_next = CNT_W'(req.index);
                            end
                        end
                        default:
                        begin
                            res_next.status = STS_BAD;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                tbl_port.raddr = i_reg[IDX_W-1:0];
                state_next     = S_SCAN_EV;
            end

            S_SCAN_EV:
            begin
                state_next = S_SCAN_RD;
                i_next     = i_inc;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (tbl_rdata.start <= addr_reg)
                        begin
                            prev_end_next = {1'b0, tbl_rdata.start} + {1'b0, tbl_rdata.length};
                            has_prev_next = 1'b1;
                            if (last_i)
                            begin
                                pos_next   = count_reg;
                                state_next = S_ADD_FIN;
                            end
                        end
                        else
                        begin
                            pos_next = i_reg;
                            if ((has_prev_reg && prev_end_reg > {1'b0, addr_reg}) ||
                                ({1'b0, tbl_rdata.start} < cut_reg))
                            begin
                                res_next.status = STS_BAD;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ins_next             = '{start: addr_reg, length: len_reg};
                                i_next               = count_reg;
                                res_next.entry_index = 5'(i_reg);
                                state_next           = S_SHUP_RD;
                            end
                        end
                    end
                    CMD_CARVE_RANGE, CMD_CONTAINS, CMD_FIRST_FIT, CMD_ALL_FITS:
                    begin
                        if (cmd_reg == CMD_FIRST_FIT || cmd_reg == CMD_ALL_FITS)
                        begin
                            hit = tbl_rdata.length >= len_reg;
                        end
                        else
                        begin
                            hit = (tbl_rdata.start <= addr_reg) &&
                                  ((addr_reg - tbl_rdata.start) < tbl_rdata.length);
                        end
                        if (hit)
                        begin
                            i_next = i_reg;
                            if (cmd_reg == CMD_CARVE_RANGE)
                            begin
                                cs_next              = tbl_rdata.start;
                                cl_next              = tbl_rdata.length;
                                cidx_next            = i_reg[IDX_W-1:0];
                                res_next.entry_index = 5'(i_reg);
                                state_next           = S_CARVE_CALC;
                            end
                            else if (cmd_reg == CMD_ALL_FITS)
                            begin
                                cand_next              = '0;
                                cand_next.entry_index  = 5'(i_reg);
                                cand_next.block_start  = tbl_rdata.start;
                                cand_next.block_length = tbl_rdata.length;
                                state_next             = S_LIST_PUSH;
                            end
                            else
                            begin
                                res_next.entry_index  = 5'(i_reg);
                                res_next.block_start  = tbl_rdata.start;
                                res_next.block_length = tbl_rdata.length;
                                state_next            = S_EMIT;
                            end
                        end
                        else if (last_i)
                        begin
                            if (cmd_reg == CMD_ALL_FITS)
                            begin
                                state_next = S_LIST_END;
                            end
                            else
                            begin
                                res_next.status = STS_NOT_FOUND;
                                state_next      = S_EMIT;
                            end
                        end
                    end
                    CMD_TOTAL:
                    begin
                        sum_next = sum_reg + 38'(tbl_rdata.length);
                        if (last_i)
                        begin
                            res_next.total_free = sum_reg + 38'(tbl_rdata.length);
                            state_next          = S_EMIT;
                        end
                    end
                    CMD_READ:
                    begin
                        res_next.block_start  = tbl_rdata.start;
                        res_next.block_length = tbl_rdata.length;
                        state_next            = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_ADD_FIN:
            begin
                if (has_prev_reg && prev_end_reg > {1'b0, addr_reg})
                begin
                    res_next.status = STS_BAD;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ins_next             = '{start: addr_reg, length: len_reg};
                    i_next               = count_reg;
                    res_next.entry_index = 5'(pos_reg);
                    state_next           = S_SHUP_RD;
                end
            end

            // one listed item is held back so the final one can carry last
            S_LIST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = cand_reg;
                    pend_valid_next = 1'b1;
                    found_next      = found_reg + 1'b1;
                    if (32'(found_reg) + 1 == LIST_MAX || last_i)
                    begin
                        state_next = S_LIST_END;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_LIST_END:
            begin
                if (pend_valid_reg)
                begin
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next.status = STS_NOT_FOUND;
                end
                pend_valid_next = 1'b0;
                state_next      = S_EMIT;
            end

            S_CARVE_RD:
            begin
                tbl_port.raddr = IDX_W'(idx_reg);
                cidx_next      = IDX_W'(idx_reg);
                state_next     = S_CARVE_LD;
            end

            S_CARVE_LD:
            begin
                cs_next    = tbl_rdata.start;
                cl_next    = tbl_rdata.length;
                state_next = S_CARVE_CALC;
            end

            S_CARVE_CALC:
            begin
                ca_next    = (cmd_reg == CMD_CARVE_FRONT) ? cs_reg : addr_reg;
                e_next     = {1'b0, cs_reg} + {1'b0, cl_reg};
                cutc_next  = {1'b0, ((cmd_reg == CMD_CARVE_FRONT) ? cs_reg : addr_reg)} +
                             {1'b0, len_reg};
                state_next = S_CARVE_DEC;
            end

            S_CARVE_DEC:
            begin
                state_next = S_EMIT;
                if (len_reg == '0 || ca_reg < cs_reg || cutc_reg > e_reg)
                begin
                    res_next.status = STS_BAD;
                end
                else if (32'(depth_reg) >= UNDO_DEPTH ||
                         (nb && na && 32'(count_reg) >= MAX_BLOCKS))
                begin
                    res_next.status = STS_FULL;
                end
                else
                begin
                    undo_port.we    = 1'b1;
                    undo_port.waddr = depth_reg[UIDX_W-1:0];
                    undo_port.wdata = '{pos: cidx_reg, pieces: {1'b0, nb} + {1'b0, na},
                                        start: cs_reg, length: cl_reg};
                    depth_next      = depth_reg + 1'b1;
                    if (!nb && !na)
                    begin
                        pos_next   = CNT_W'(cidx_reg);
                        i_next     = CNT_W'(cidx_reg);
                        state_next = S_SHDN_RD;
                    end
                    else if (nb)
                    begin
                        tbl_port.we    = 1'b1;
                        tbl_port.waddr = cidx_reg;
                        tbl_port.wdata = '{start: cs_reg, length: ca_reg - cs_reg};
                        if (na)
                        begin
                            pos_next   = CNT_W'(cidx_reg) + 1'b1;
                            i_next     = count_reg;
                            ins_next   = '{start: cutc_reg[31:0],
                                           length: 32'(e_reg - cutc_reg)};
                            state_next = S_SHUP_RD;
                        end
                    end
                    else
                    begin
                        tbl_port.we    = 1'b1;
                        tbl_port.waddr = cidx_reg;
                        tbl_port.wdata = '{start: cutc_reg[31:0],
                                           length: 32'(e_reg - cutc_reg)};
                    end
                end
            end

            S_UNDO_RD:
            begin
                undo_port.raddr = UIDX_W'(depth_reg - 1'b1);
                state_next      = S_UNDO_DEC;
            end

            S_UNDO_DEC:
            begin
                res_next.entry_index = 5'(undo_rdata.pos);
                state_next           = S_EMIT;
                if (undo_rdata.pieces == 2'd0)
                begin
                    if (32'(undo_rdata.pos) > 32'(count_reg))
                    begin
                        res_next.status = STS_BAD;
                    end
                    else if (32'(count_reg) >= MAX_BLOCKS)
                    begin
                        res_next.status = STS_FULL;
                    end
                    else
                    begin
                        ins_next   = '{start: undo_rdata.start, length: undo_rdata.length};
                        pos_next   = upos;
                        i_next     = count_reg;
                        depth_next = depth_reg - 1'b1;
                        state_next = S_SHUP_RD;
                    end
                end
                else
                begin
                    if (32'(undo_rdata.pos) + 32'(undo_rdata.pieces) > 32'(count_reg))
                    begin
                        res_next.status = STS_BAD;
                    end
                    else
                    begin
                        tbl_port.we    = 1'b1;
                        tbl_port.waddr = undo_rdata.pos;
                        tbl_port.wdata = '{start: undo_rdata.start, length: undo_rdata.length};
                        depth_next     = depth_reg - 1'b1;
                        if (undo_rdata.pieces == 2'd2)
                        begin
                            pos_next   = upos + 1'b1;
                            i_next     = upos + 1'b1;
                            state_next = S_SHDN_RD;
                        end
                    end
                end
            end

            // open a gap at pos_reg, moving entries up from the top
            S_SHUP_RD:
            begin
                if (i_reg > pos_reg)
                begin
                    tbl_port.raddr = i_dec[IDX_W-1:0];
                    state_next     = S_SHUP_WR;
                end
                else
                begin
                    tbl_port.we    = 1'b1;
                    tbl_port.waddr = pos_reg[IDX_W-1:0];
                    tbl_port.wdata = ins_reg;
                    count_next     = count_reg + 1'b1;
                    state_next     = S_EMIT;
                end
            end

            S_SHUP_WR:
            begin
                tbl_port.we    = 1'b1;
                tbl_port.waddr = i_reg[IDX_W-1:0];
                tbl_port.wdata = tbl_rdata;
                i_next         = i_dec;
                state_next     = S_SHUP_RD;
            end

            // close the gap at pos_reg, moving entries down
            S_SHDN_RD:
            begin
                if (i_inc < count_reg)
                begin
                    tbl_port.raddr = i_inc[IDX_W-1:0];
                    state_next     = S_SHDN_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_EMIT;
                end
            end

            S_SHDN_WR:
            begin
                tbl_port.we    = 1'b1;
                tbl_port.waddr = i_reg[IDX_W-1:0];
                tbl_port.wdata = tbl_rdata;
                i_next         = i_inc;
                state_next     = S_SHDN_RD;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_BLOCKS)
        else $error("entry count beyond table size");

    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= UNDO_DEPTH)
        else $error("undo depth beyond stack size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped by more than one");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_port.we |-> 32'(tbl_port.waddr) <= 32'(count_reg))
        else $error("table write beyond occupied range");

endmodule

// ===== sv/free_block_list_allocator.sv =====
// top level: sequencer with block table ram and undo stack ram
// a table walk reads each entry from the ram and then evaluates it
// shifting moves entries one at a time, a ram read then a write; add, carve and undo shift
// entries where needed; all fits passes each listed item through a push step
// that waits while the output is stalled; one item in flight, the next accepted
// while the last result waits; reset clears entry count and undo depth, rams keep contents
`timescale 1ns / 1ps
module free_block_list_allocator
    import fbla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    tbl_port_t  tbl_port;
    tbl_entry_t tbl_rdata;
    undo_port_t undo_port;
    undo_rec_t  undo_rdata;

    fbla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .tbl_port   (tbl_port),
        .tbl_rdata  (tbl_rdata),
        .undo_port  (undo_port),
        .undo_rdata (undo_rdata)
    );

    fbla_ram #(
        .WIDTH ($bits(tbl_entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_port.we),
        .waddr (tbl_port.waddr),
        .wdata (tbl_port.wdata),
        .raddr (tbl_port.raddr),
        .rdata (tbl_rdata)
    );

    fbla_ram #(
        .WIDTH ($bits(undo_rec_t)),
        .DEPTH (UNDO_DEPTH)
    ) u_undo_ram (
        .clk   (clk),
        .we    (undo_port.we),
        .waddr (undo_port.waddr),
        .wdata (undo_port.wdata),
        .raddr (undo_port.raddr),
        .rdata (undo_rdata)
    );

endmodule

// ===== dv/fbla_checker.sv =====
// checker for the free block list allocator: tracks the block table and compares results
`timescale 1ns / 1ps
module fbla_checker
    import fbla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   pending_results,
    output int   fail_count
);

    logic [31:0] blk_start [MAX_BLOCKS];
    logic [31:0] blk_len   [MAX_BLOCKS];
    int unsigned n_blocks;
    int unsigned rec_pos    [UNDO_DEPTH];
    int unsigned rec_pieces [UNDO_DEPTH];
    logic [31:0] rec_start  [UNDO_DEPTH];
    logic [31:0] rec_len    [UNDO_DEPTH];
    int unsigned undo_used;
    rsp_t        expected_q [$];

    function automatic void push_result(logic [1:0] st, int unsigned idx, logic [31:0] bs,
                                        logic [31:0] bl, logic [37:0] tot, logic lst);
        rsp_t r;
        r.status       = st;
        r.entry_index  = idx[4:0];
        r.block_start  = bs;
        r.block_length = bl;
        r.total_free   = tot;
        r.last         = lst;
        expected_q = {expected_q, r};
    endfunction

    function automatic void insert_block(int unsigned pos, logic [31:0] s, logic [31:0] l);
        for (int unsigned i = n_blocks; i > pos; i--)
        begin
            blk_start[i] = blk_start[i-1];
            blk_len[i]   = blk_len[i-1];
        end
        blk_start[pos] = s;
        blk_len[pos]   = l;
        n_blocks++;
    endfunction

    function automatic void remove_block(int unsigned pos);
        for (int unsigned i = pos; i + 1 < n_blocks; i++)
        begin
            blk_start[i] = blk_start[i+1];
            blk_len[i]   = blk_len[i+1];
        end
        n_blocks--;
    endfunction

    function automatic logic [1:0] carve_block(int unsigned idx, longint unsigned a,
                                               longint unsigned l);
        longint unsigned s, e, cut_end;
        int unsigned     nb, na, t;
        if (idx >= n_blocks || l == 0)
            return STS_BAD;
        s       = blk_start[idx];
        e       = s + blk_len[idx];
        cut_end = a + l;
        if (a < s || cut_end > e)
            return STS_BAD;
        nb = (a > s);
        na = (e > cut_end);
        if (undo_used >= UNDO_DEPTH)
            return STS_FULL;
        if (nb + na == 2 && n_blocks >= MAX_BLOCKS)
            return STS_FULL;
        t = undo_used++;
        rec_pos[t]    = idx;
        rec_pieces[t] = nb + na;
        rec_start[t]  = blk_start[idx];
        rec_len[t]    = blk_len[idx];
        if (nb + na == 0)
            remove_block(idx);
        else if (nb != 0)
        begin
            blk_len[idx] = 32'(a - s);
            if (na != 0)
                insert_block(idx + 1, 32'(cut_end), 32'(e - cut_end));
        end
        else
        begin
            blk_start[idx] = 32'(cut_end);
            blk_len[idx]   = 32'(e - cut_end);
        end
        return STS_OK;
    endfunction

    function automatic int find_block(longint unsigned a);
        for (int unsigned i = 0; i < n_blocks; i++)
            if (a >= blk_start[i] && a - blk_start[i] < blk_len[i])
                return int'(i);
        return -1;
    endfunction

    function automatic void predict_results(req_t r);
        longint unsigned a, l, sum;
        int unsigned     pos, t, n, k;
        int              f;
        a = r.address & ADDR_MASK;
        l = r.length;
        case (r.cmd)
            CMD_ADD:
            begin
                if (l == 0 || a + l > ADDR_LIMIT)
                    push_result(STS_BAD, 0, 0, 0, 0, 1);
                else if (n_blocks >= MAX_BLOCKS)
                    push_result(STS_FULL, 0, 0, 0, 0, 1);
                else
                begin
                    pos = 0;
                    while (pos < n_blocks && blk_start[pos] <= a)
                        pos++;
                    if ((pos > 0 && longint'(blk_start[pos-1]) + blk_len[pos-1] > a) ||
                        (pos < n_blocks && blk_start[pos] < a + l))
                        push_result(STS_BAD, 0, 0, 0, 0, 1);
                    else
                    begin
                        insert_block(pos, 32'(a), 32'(l));
                        push_result(STS_OK, pos, 0, 0, 0, 1);
                    end
                end
            end
            CMD_CARVE_IDX:
                push_result(carve_block(r.index, a, l), r.index, 0, 0, 0, 1);
            CMD_CARVE_FRONT:
                if (r.index >= n_blocks)
                    push_result(STS_BAD, r.index, 0, 0, 0, 1);
                else
                    push_result(carve_block(r.index, blk_start[r.index], l), r.index,
                                0, 0, 0, 1);
            CMD_CARVE_RANGE:
            begin
                f = find_block(a);
                if (f < 0)
                    push_result(STS_NOT_FOUND, 0, 0, 0, 0, 1);
                else
                    push_result(carve_block(f, a, l), f, 0, 0, 0, 1);
            end
            CMD_UNDO:
            begin
                if (undo_used == 0)
                    push_result(STS_BAD, 0, 0, 0, 0, 1);
                else
                begin
                    t   = undo_used - 1;
                    pos = rec_pos[t];
                    n   = rec_pieces[t];
                    if (n == 0 && pos > n_blocks)
                        push_result(STS_BAD, pos, 0, 0, 0, 1);
                    else if (n == 0 && n_blocks >= MAX_BLOCKS)
                        push_result(STS_FULL, pos, 0, 0, 0, 1);
                    else if (n != 0 && pos + n > n_blocks)
                        push_result(STS_BAD, pos, 0, 0, 0, 1);
                    else
                    begin
                        if (n == 0)
                            insert_block(pos, rec_start[t], rec_len[t]);
                        else
                        begin
                            blk_start[pos] = rec_start[t];
                            blk_len[pos]   = rec_len[t];
                            if (n == 2)
                                remove_block(pos + 1);
                        end
                        undo_used = t;
                        push_result(STS_OK, pos, 0, 0, 0, 1);
                    end
                end
            end
            CMD_CONTAINS:
            begin
                f = find_block(a);
                if (f < 0)
                    push_result(STS_NOT_FOUND, 0, 0, 0, 0, 1);
                else
                    push_result(STS_OK, f, blk_start[f], blk_len[f], 0, 1);
            end
            CMD_FIRST_FIT:
            begin
                f = -1;
                for (int unsigned i = 0; i < n_blocks && f < 0; i++)
                    if (blk_len[i] >= l)
                        f = int'(i);
                if (f < 0)
                    push_result(STS_NOT_FOUND, 0, 0, 0, 0, 1);
                else
                    push_result(STS_OK, f, blk_start[f], blk_len[f], 0, 1);
            end
            CMD_ALL_FITS:
            begin
                k = 0;
                for (int unsigned i = 0; i < n_blocks && k < LIST_MAX; i++)
                    if (blk_len[i] >= l)
                    begin
                        push_result(STS_OK, i, blk_start[i], blk_len[i], 0, 0);
                        k++;
                    end
                if (k == 0)
                    push_result(STS_NOT_FOUND, 0, 0, 0, 0, 1);
                else
                    expected_q[$].last = 1'b1;
            end
            CMD_TOTAL:
            begin
                sum = 0;
                for (int unsigned i = 0; i < n_blocks; i++)
                    sum += blk_len[i];
                push_result(STS_OK, 0, 0, 0, 38'(sum), 1);
            end
            CMD_READ:
                if (r.index >= n_blocks)
                    push_result(STS_BAD, r.index, 0, 0, 0, 1);
                else
                    push_result(STS_OK, r.index, blk_start[r.index], blk_len[r.index], 0, 1);
            default:
                push_result(STS_BAD, 0, 0, 0, 0, 1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            n_blocks   = 0;
            undo_used  = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (req_valid && req_ready)
                predict_results(req);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item %h", rsp);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result mismatch: exp st=%0d idx=%0d bs=%h bl=%h tot=%h last=%b",
                                     want.status, want.entry_index, want.block_start,
                                     want.block_length, want.total_free, want.last);
                            $display("                 got st=%0d idx=%0d bs=%h bl=%h tot=%h last=%b",
                                     rsp.status, rsp.entry_index, rsp.block_start,
                                     rsp.block_length, rsp.total_free, rsp.last);
                        end
                    end
                end
            end
        end
        pending_results = expected_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
// testbench top: stimulus, receiver stalls and verdict for the free block list allocator
`timescale 1ns / 1ps
module testbench;
    import fbla_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          RANDOM_ITEMS  = 445;
    localparam int          CALM_ITEMS    = 60;
    localparam int          DRAIN_CYCLES  = 200;
    localparam logic [3:0]  CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   pending_results;
    int   fail_count;
    int   cycle_count = 0;
    int   hold_cycles = 0;
    bit   calm = 1'b0;

    always #6 clk = ~clk;

    free_block_list_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    fbla_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .pending_results(pending_results), .fail_count(fail_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("free_block_list_allocator: mismatch");
            $finish;
        end
    end

    // result side: random stall bursts, or a long hold-off when asked
    always @(posedge clk)
    begin
        int stall_left;
        if (!rst_n)
            stall_left = 0;
        else if (hold_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (calm)
            rsp_ready <= 1'b1;
        else
        begin
            if (stall_left == 0 && $urandom_range(0, 99) < 15)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [3:0] c, int i, logic [31:0] a, logic [31:0] l);
        req_t r;
        r.cmd     = c;
        r.index   = 5'(i);
        r.address = a;
        r.length  = l;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic idle_input(int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // mostly well-formed traffic in a small address window, with some full-range noise
    task automatic send_random_item();
        int          pick;
        logic [3:0]  c;
        int          i;
        logic [31:0] a, l;
        pick = $urandom_range(0, 99);
        i    = $urandom_range(0, 15);
        a    = $urandom_range(0, 8191);
        l    = $urandom_range(1, 64);
        if (pick < 25)
        begin
            c = CMD_ADD;
            l = $urandom_range(1, 300);
        end
        else if (pick < 35)
            c = CMD_CARVE_IDX;
        else if (pick < 50)
            c = CMD_CARVE_FRONT;
        else if (pick < 65)
            c = CMD_CARVE_RANGE;
        else if (pick < 75)
            c = CMD_UNDO;
        else if (pick < 80)
            c = CMD_CONTAINS;
        else if (pick < 85)
            c = CMD_FIRST_FIT;
        else if (pick < 90)
        begin
            c = CMD_ALL_FITS;
            l = $urandom_range(0, 100);
        end
        else if (pick < 94)
            c = CMD_TOTAL;
        else if (pick < 98)
        begin
            c = CMD_READ;
            i = $urandom_range(0, 31);
        end
        else
            c = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        if ($urandom_range(0, 9) == 0)
            a = $urandom;
        if ($urandom_range(0, 9) == 0)
            l = $urandom;
        if ($urandom_range(0, 9) == 0)
            i = $urandom_range(0, 31);
        send_item(c, i, a, l);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table and empty undo stack
        send_item(CMD_UNDO, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0);
        send_item(CMD_CONTAINS, 0, 32'h10, 0);
        send_item(CMD_FIRST_FIT, 0, 0, 1);
        send_item(CMD_ALL_FITS, 0, 0, 0);
        send_item(CMD_TOTAL, 0, 0, 0);
        // adds: zero length, crossing the top of the address space, overlaps and valid blocks
        send_item(CMD_ADD, 0, 32'h100, 0);
        send_item(CMD_ADD, 0, 32'hFFFF_FFFF, 2);
        send_item(CMD_ADD, 0, 32'hFFFF_FFFF, 1);
        send_item(CMD_ADD, 0, 32'h0, 32'h10);
        send_item(CMD_ADD, 0, 32'h8, 32'h10);
        send_item(CMD_ADD, 0, 32'h100, 32'h50);
        send_item(CMD_ADD, 0, 32'h1000, 32'hFFFF_E000);
        send_item(CMD_TOTAL, 0, 0, 0);
        // two-piece split, front carve, end carve, out-of-range carve, range miss, then undos
        send_item(CMD_CARVE_IDX, 1, 32'h110, 32'h10);
        send_item(CMD_CARVE_FRONT, 0, 0, 4);
        send_item(CMD_CARVE_RANGE, 0, 32'h0C, 4);
        send_item(CMD_CARVE_IDX, 2, 32'h140, 32'h20);
        send_item(CMD_CARVE_RANGE, 0, 32'h800, 4);
        send_item(CMD_ALL_FITS, 0, 0, 1);
        send_item(CMD_UNDO, 0, 0, 0);
        send_item(CMD_UNDO, 0, 0, 0);
        send_item(CMD_UNDO, 0, 0, 0);
        send_item(CMD_READ, 31, 0, 0);
        send_item(CMD_UNUSED_HI, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 150)
                hold_cycles <= 400;
            if (n == 300)
            begin
                req_valid <= 1'b0;
                // let the checker take in the last accepted item first
                @(posedge clk);
                wait (pending_results == 0);
                idle_input(DRAIN_CYCLES);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 99) < 30)
                idle_input($urandom_range(1, 4));
            send_random_item();
        end
        req_valid <= 1'b0;
        calm = 1'b1;

        @(posedge clk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("free_block_list_allocator: match");
        else
            $display("free_block_list_allocator: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fbla_pkg.sv
sv/fbla_ram.sv
sv/fbla_ctrl.sv
sv/free_block_list_allocator.sv
dv/fbla_checker.sv
dv/testbench.sv
